>>> design/ils_pkg.sv
package ils_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
  localparam int GROUP_SZ = 8;
  localparam int GROUPS   = (DEPTH + GROUP_SZ - 1) / GROUP_SZ;
  localparam int SLOTS    = GROUPS * GROUP_SZ;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_HEAD   = 3'd1;
  localparam logic [2:0] CMD_TAIL   = 3'd2;
  localparam logic [2:0] CMD_BEFORE = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [7:0]  position;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               read_valid;
    logic               op_done;
    logic               full_drop;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_READ,
    OP_INSERT,
    OP_DELETE
  } op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    op_t   op;
    idx_t  at;
    word_t value;
  } ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_APPLY  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

>>> design/indexed_list_store_top.sv
// Ordered list of up to DEPTH 32-bit entries held in a chain of cells, one entry per
// cell. Insert shifts every cell above the insert point up by one from its lower
// neighbour, delete shifts them down from the upper neighbour, so every cell shifts
// at once regardless of position. A read gates the addressed cell onto an OR bus that is
// reduced in groups of eight into registers, then across groups into the response.
// Each word is accepted in the idle state; the apply state then applies the shift or
// captures the read groups, and the finish state loads the response register. A new
// request word is taken once the previous result has moved into the response
// register, so one request is in flight at a time and the next word waits while the
// response side is stalled. There is no clearing pass after reset; entries at or above
// the count are never read.
module indexed_list_store_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  state_t state;
  req_t   item;
  rsp_t   res;
  rsp_t   res_next;
  rsp_t   rsp_next;
  cnt_t   count;
  cnt_t   count_next;
  ctrl_t  ctrl;

  logic             pos_nonneg;
  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] cnt_u;
  logic [CMP_W-1:0] ins_u;
  logic             load_rsp;

  word_t cell_data [DEPTH];
  word_t rd_word   [SLOTS];
  word_t groups    [GROUPS];
  word_t gathered;

  assign req_ready = (state == S_IDLE);
  assign load_rsp  = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  assign pos_nonneg = !item.position[7];
  assign pos_u      = CMP_W'(item.position[6:0]);
  assign cnt_u      = CMP_W'(count);

  always_comb begin
    case (item.command)
      CMD_HEAD: ins_u = '0;
      CMD_TAIL: ins_u = cnt_u;
      default:  ins_u = pos_nonneg ? pos_u : '0;
    endcase
  end

  always_comb begin
    ctrl       = '{op: OP_HOLD, at: '0, value: word_t'(item.data_in)};
    count_next = count;
    res_next   = '0;
    case (item.command)
      CMD_READ: begin
        if (pos_nonneg && pos_u < cnt_u) begin
          ctrl.op             = OP_READ;
          ctrl.at             = IDX_W'(pos_u);
          res_next.read_valid = 1'b1;
        end else begin
          res_next.read_data = '1;
        end
      end
      CMD_HEAD, CMD_TAIL, CMD_BEFORE: begin
        // out-of-range insert point is dropped before the full check
        if (ins_u <= cnt_u) begin
          if (count >= CNT_W'(DEPTH)) begin
            res_next.full_drop = 1'b1;
          end else begin
            ctrl.op          = OP_INSERT;
            ctrl.at          = IDX_W'(ins_u);
            count_next       = count + cnt_t'(1);
            res_next.op_done = 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (pos_nonneg && pos_u < cnt_u) begin
          ctrl.op          = OP_DELETE;
          ctrl.at          = IDX_W'(pos_u);
          count_next       = count - cnt_t'(1);
          res_next.op_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_next.entry_count = 7'(count_next);
    // a read stays on the bus while the response register is stalled
    if (state != S_APPLY && !(state == S_FINISH && ctrl.op == OP_READ)) begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i < DEPTH) begin : g_used
      word_t left;
      word_t right;
      if (i > 0) begin : g_left
        assign left = cell_data[i-1];
      end else begin : g_left0
        assign left = '0;
      end
      if (i < DEPTH - 1) begin : g_right
        assign right = cell_data[i+1];
      end else begin : g_right0
        assign right = '0;
      end
      ils_cell u_cell (
        .clk   (clk),
        .index (IDX_W'(i)),
        .ctrl  (ctrl),
        .left  (left),
        .right (right),
        .data  (cell_data[i]),
        .rd    (rd_word[i])
      );
    end else begin : g_pad
      assign rd_word[i] = '0;
    end
  end

  ils_gather u_gather (
    .clk    (clk),
    .words  (rd_word),
    .groups (groups)
  );

  always_comb begin
    gathered = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gathered = gathered | groups[g];
    end
  end

  always_comb begin
    rsp_next = res;
    if (res.read_valid) begin
      rsp_next.read_data = gathered;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          count <= count_next;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (load_rsp) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (state == S_APPLY) begin
      res <= res_next;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> design/ils_cell.sv
module ils_cell (
  input  logic          clk,
  input  ils_pkg::idx_t  index,
  input  ils_pkg::ctrl_t ctrl,
  input  ils_pkg::word_t left,
  input  ils_pkg::word_t right,
  output ils_pkg::word_t data,
  output ils_pkg::word_t rd
);
  import ils_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (index > ctrl.at) begin
          data <= left;
        end else if (index == ctrl.at) begin
          data <= ctrl.value;
        end
      end
      OP_DELETE: begin
        if (index >= ctrl.at) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // gated so the gather stage can simply OR all cells together
  assign rd = (ctrl.op == OP_READ && index == ctrl.at) ? data : '0;

endmodule

>>> design/ils_gather.sv
module ils_gather (
  input  logic           clk,
  input  ils_pkg::word_t words  [ils_pkg::SLOTS],
  output ils_pkg::word_t groups [ils_pkg::GROUPS]
);
  import ils_pkg::*;

  word_t group_or [GROUPS];

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        group_or[g] = group_or[g] | words[g * GROUP_SZ + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      groups[g] <= group_or[g];
    end
  end

endmodule

>>> tb/list_store_checker.sv
module list_store_checker
  import ils_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] list_model[$];
  rsp_t               due_results[$];
  int                 errors = 0;

  // applies one command word to the model list and returns the result it gives
  function automatic rsp_t apply_command(req_t w);
    rsp_t r;
    int   pos;
    int   at;
    int   n;
    r   = '0;
    pos = int'($signed(w.position));
    n   = list_model.size();
    case (w.command)
      CMD_READ: begin
        if (pos >= 0 && pos < n) begin
          r.read_data  = list_model[pos];
          r.read_valid = 1'b1;
        end else begin
          r.read_data = -32'sd1;
        end
      end
      CMD_HEAD, CMD_TAIL, CMD_BEFORE: begin
        if (w.command == CMD_HEAD) begin
          at = 0;
        end else if (w.command == CMD_TAIL) begin
          at = n;
        end else begin
          at = (pos < 0) ? 0 : pos;
        end
        // an insert point past the end is dropped silently, ahead of the full check
        if (at <= n) begin
          if (n >= DEPTH) begin
            r.full_drop = 1'b1;
          end else begin
            list_model.insert(at, w.data_in);
            r.op_done = 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (pos >= 0 && pos < n) begin
          list_model.delete(pos);
          r.op_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 7'(list_model.size());
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_model.delete();
      due_results.delete();
    end else begin
      // result first: a word accepted at this edge cannot be answered at the same edge
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected result word: data=%h valid=%b done=%b full=%b count=%0d",
                     rsp.read_data, rsp.read_valid, rsp.op_done, rsp.full_drop,
                     rsp.entry_count);
          end
        end else begin
          want = due_results.pop_front();
          if (rsp.read_data !== want.read_data || rsp.read_valid !== want.read_valid ||
              rsp.op_done !== want.op_done || rsp.full_drop !== want.full_drop ||
              rsp.entry_count !== want.entry_count) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("result mismatch: expected data=%h valid=%b done=%b full=%b count=%0d",
                       want.read_data, want.read_valid, want.op_done, want.full_drop,
                       want.entry_count);
              $display("                 actual   data=%h valid=%b done=%b full=%b count=%0d",
                       rsp.read_data, rsp.read_valid, rsp.op_done, rsp.full_drop,
                       rsp.entry_count);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        due_results.push_back(apply_command(req));
      end
    end
    pending    <= due_results.size();
    fail_count <= errors;
  end

endmodule

>>> tb/tb_indexed_list_store_top.sv
module tb_indexed_list_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int         RANDOM_ITEMS   = 1025;
  localparam int         MODE_SPAN      = 120;
  localparam int         CALM_FROM      = 480;
  localparam int         CALM_TO        = 640;
  localparam int         IDLE_PCT       = 14;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         TAIL_CYCLES    = 12;
  localparam logic [2:0] CMD_LAST       = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } mode_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  logic       rsp_ready  = 1'b0;
  req_t       req        = '0;
  logic       calm       = 1'b0;
  logic [6:0] seen_count = '0;
  int         quiet_cycles = 0;
  logic       req_ready;
  logic       rsp_valid;
  rsp_t       rsp;
  int         fail_count;
  int         pending;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  indexed_list_store_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  list_store_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // valid is only lowered when a gap is taken, so it never drops and rises in one step
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] pos,
                           input logic [31:0] value);
    int   gap;
    req_t w;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.command  = cmd;
    w.position = pos;
    w.data_in  = value;
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic random_word(input mode_t mode);
    int          roll;
    int          ins_pct;
    int          read_pct;
    int          del_pct;
    logic [2:0]  cmd;
    logic [7:0]  pos;
    logic [31:0] value;
    case (mode)
      MODE_FILL: begin
        ins_pct  = 75;
        read_pct = 10;
        del_pct  = 10;
      end
      MODE_DRAIN: begin
        ins_pct  = 20;
        read_pct = 20;
        del_pct  = 55;
      end
      default: begin
        ins_pct  = 45;
        read_pct = 25;
        del_pct  = 25;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_HEAD;
        1:       cmd = CMD_TAIL;
        default: cmd = CMD_BEFORE;
      endcase
    end else if (roll < ins_pct + read_pct) begin
      cmd = CMD_READ;
    end else if (roll < ins_pct + read_pct + del_pct) begin
      cmd = CMD_DELETE;
    end else begin
      cmd = 3'($urandom_range(CMD_DELETE + 1, CMD_LAST));
    end
    // positions mostly near the live range, the rest anywhere in the 8-bit field
    if ($urandom_range(0, 4) == 0) begin
      pos = 8'($urandom);
    end else begin
      pos = 8'($urandom_range(0, seen_count + 1));
    end
    case ($urandom_range(0, 15))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = 32'h0000_0000;
      3:       value = 32'hffff_ffff;
      default: value = $urandom;
    endcase
    send_word(cmd, pos, value);
  endtask

  initial begin
    mode_t mode;
    mode = MODE_FILL;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty store
    send_word(CMD_READ,   8'sd0,    32'h1111_1111);
    send_word(CMD_READ,   -8'sd128, 32'h0);
    send_word(CMD_DELETE, 8'sd0,    32'h0);
    send_word(CMD_BEFORE, 8'sd1,    32'h2222_2222);
    send_word(3'd5,       8'sd0,    32'hffff_ffff);
    // build a short list, negative position goes to the head
    send_word(CMD_TAIL,   8'sd0,    32'h7fff_ffff);
    send_word(CMD_HEAD,   8'sd9,    32'h8000_0000);
    send_word(CMD_BEFORE, -8'sd1,   32'h0000_0000);
    send_word(CMD_BEFORE, 8'sd3,    32'hffff_ffff);
    send_word(CMD_BEFORE, 8'sd5,    32'h3333_3333);
    send_word(CMD_READ,   8'sd0,    32'h0);
    send_word(CMD_READ,   8'sd1,    32'h0);
    send_word(CMD_READ,   8'sd2,    32'h0);
    send_word(CMD_READ,   8'sd3,    32'h0);
    send_word(CMD_READ,   8'sd4,    32'h0);
    send_word(CMD_READ,   8'sd127,  32'h0);
    // deletes off the ends and out of range
    send_word(CMD_DELETE, -8'sd1,   32'h0);
    send_word(CMD_DELETE, 8'sd4,    32'h0);
    send_word(CMD_DELETE, 8'sd3,    32'h0);
    send_word(CMD_DELETE, 8'sd0,    32'h0);
    send_word(CMD_BEFORE, 8'sd1,    32'h5555_5555);
    send_word(CMD_READ,   8'sd1,    32'h0);
    send_word(3'd6,       8'sd1,    32'haaaa_aaaa);
    send_word(CMD_LAST,   -8'sd128, 32'h0);
    send_word(CMD_DELETE, 8'sd127,  32'h0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % MODE_SPAN == 0) begin
        if (i < 2 * MODE_SPAN) begin
          mode = MODE_FILL;
        end else if (i < 3 * MODE_SPAN) begin
          mode = MODE_DRAIN;
        end else begin
          mode = mode_t'($urandom_range(0, 2));
        end
      end
      if (i == CALM_FROM) calm <= 1'b1;
      if (i == CALM_TO) calm <= 1'b0;
      random_word(mode);
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rsp_valid && rsp_ready) seen_count <= rsp.entry_count;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
